@@ hdl/kid_pkg.sv @@
`timescale 1ns / 1ps

package kid_pkg;

    localparam int DEPTH   = 256;
    localparam int KEY_W   = 32;
    localparam int IDX_W   = 11;
    localparam int BASE_W  = 10;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W   = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
    localparam int SUM_W   = ((SLOT_W > BASE_W) ? SLOT_W : BASE_W) + 1;

    localparam logic [CMD_W-1:0] CMD_PUT      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLACE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KEY2IDX  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_IDX2KEY  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    // Request token walking the cell row; first a lookup pass, then an update pass.
    typedef struct packed {
        logic               valid;
        logic               apply;
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic               force_app;
        logic [SLOT_W-1:0]  slot;
        logic               slot_ok;
        logic [COUNT_W-1:0] count;
        logic               hit;
        logic [SLOT_W-1:0]  hit_slot;
        logic [KEY_W-1:0]   old_key;
        logic               unmap;
        logic               wr_en;
        logic               wr_mapped;
    } t_token;

endpackage

@@ hdl/kid_if.sv @@
`timescale 1ns / 1ps

interface kid_req_if import kid_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key_value;
    logic             force_append;
    logic [IDX_W-1:0] index_in;

    modport source (output valid, output command, output key_value, output force_append,
                    output index_in, input ready);
    modport sink   (input valid, input command, input key_value, input force_append,
                    input index_in, output ready);
endinterface

interface kid_rsp_if import kid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index_out;
    logic [KEY_W-1:0]  key_out;
    logic              was_added;
    logic [STAT_W-1:0] status;

    modport source (output valid, output index_out, output key_out, output was_added,
                    output status, input ready);
    modport sink   (input valid, input index_out, input key_out, input was_added,
                    input status, output ready);
endinterface

@@ hdl/kid_cell.sv @@
`timescale 1ns / 1ps

module kid_cell import kid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_cell_idx,
    input  t_token            i_tok,
    output t_token            o_tok
);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             r_mapped;
    logic             n_mapped;
    t_token           r_tok;
    t_token           n_tok;
    logic             w_in_range;
    logic             w_here;

    assign w_in_range = COUNT_W'(i_cell_idx) < i_tok.count;
    assign w_here     = i_tok.slot == i_cell_idx;

    always_comb begin
        n_tok    = i_tok;
        n_key    = r_key;
        n_mapped = r_mapped;
        if (i_tok.valid) begin
            if (!i_tok.apply) begin
                // only one written slot can be mapped to a given key
                if (w_in_range && r_mapped && (r_key == i_tok.key)) begin
                    n_tok.hit      = 1'b1;
                    n_tok.hit_slot = i_cell_idx;
                end
                if (w_in_range && w_here) begin
                    n_tok.old_key = r_key;
                end
            end else begin
                if (i_tok.unmap && w_in_range &&
                    ((r_key == i_tok.old_key) || (r_key == i_tok.key))) begin
                    n_mapped = 1'b0;
                end
                // the write of the target slot wins over the unmap
                if (i_tok.wr_en && w_here) begin
                    n_key    = i_tok.key;
                    n_mapped = i_tok.wr_mapped;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (!i_rst_n) begin
            r_mapped    <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_mapped <= n_mapped;
            r_tok    <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ hdl/kid_chain.sv @@
`timescale 1ns / 1ps

module kid_chain import kid_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    output t_token o_tok
);

    t_token w_tok [DEPTH+1];

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        kid_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (SLOT_W'(g)),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[DEPTH];

endmodule

@@ hdl/key_index_dictionary.sv @@
`timescale 1ns / 1ps

// Key/index dictionary built as a row of DEPTH slot cells.
// i_req carries one command per request (put, replace, key to index, index to
// key); o_rsp returns exactly one response per request, in order. Both use
// valid/ready; a request is taken when valid and ready are high at a clock edge.
// i_cfg_wr_en/i_cfg_wr_data set the index base; write it only while idle.
// Each request walks the cell row twice, one cell per cycle: a lookup pass that
// collects the match and the key at the addressed slot, then an update pass
// that appends, rebinds or unmaps. The response is registered at the end of the
// lookup pass; the next request is taken only after the update pass has left
// the row.
// Reset clears the mapped bits, the entry count and the base; stored keys are
// not cleared and are read only after being written.
// A stalled response sits in the output register; a second result waits in a
// pending register, and no new request is taken until it has moved on.
module key_index_dictionary import kid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BASE_W-1:0] i_cfg_wr_data,
    kid_req_if.sink           i_req,
    kid_rsp_if.source         o_rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_GATHER = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    t_token             r_inj;
    t_token             n_inj;
    t_token             w_tail;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [BASE_W-1:0]  r_base;

    logic               r_pend;
    logic [IDX_W-1:0]   r_res_index;
    logic [KEY_W-1:0]   r_res_key;
    logic               r_res_added;
    logic [STAT_W-1:0]  r_res_status;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_index;
    logic [KEY_W-1:0]   r_out_key;
    logic               r_out_added;
    logic [STAT_W-1:0]  r_out_status;

    logic               w_accept;
    logic               w_gather_end;
    logic               w_apply_end;
    logic               w_load_out;
    logic [CMP_W-1:0]   w_idx_ext;
    logic [CMP_W-1:0]   w_base_ext;
    logic [CMP_W-1:0]   w_diff;
    logic               w_slot_ok;
    logic [IDX_W-1:0]   w_hit_index;
    logic [IDX_W-1:0]   w_app_index;
    logic               w_full;
    t_token             w_gather_tok;
    t_token             w_apply_tok;
    logic [IDX_W-1:0]   w_res_index;
    logic [KEY_W-1:0]   w_res_key;
    logic               w_res_added;
    logic [STAT_W-1:0]  w_res_status;

    kid_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (r_inj),
        .o_tok   (w_tail)
    );

    assign i_req.ready  = (r_state == S_IDLE) && !r_pend;
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_gather_end = (r_state == S_GATHER) && w_tail.valid && !w_tail.apply;
    assign w_apply_end  = (r_state == S_APPLY) && w_tail.valid && w_tail.apply;
    assign w_load_out   = r_pend && (!r_out_valid || o_rsp.ready);

    // external index to slot number
    assign w_idx_ext  = CMP_W'(i_req.index_in);
    assign w_base_ext = CMP_W'(r_base);
    assign w_diff     = w_idx_ext - w_base_ext;
    assign w_slot_ok  = (w_idx_ext >= w_base_ext) && (w_diff < CMP_W'(r_count));

    assign w_hit_index = IDX_W'(SUM_W'(w_tail.hit_slot) + SUM_W'(r_base));
    assign w_app_index = IDX_W'(SUM_W'(w_tail.count[SLOT_W-1:0]) + SUM_W'(r_base));
    assign w_full      = w_tail.count == COUNT_W'(DEPTH);

    always_comb begin
        w_gather_tok           = '0;
        w_gather_tok.valid     = 1'b1;
        w_gather_tok.cmd       = i_req.command;
        w_gather_tok.key       = i_req.key_value;
        w_gather_tok.force_app = i_req.force_append;
        w_gather_tok.slot      = SLOT_W'(w_diff);
        w_gather_tok.slot_ok   = w_slot_ok;
        w_gather_tok.count     = r_count;
    end

    // decide the response and the update pass from the lookup results
    always_comb begin
        w_apply_tok       = w_tail;
        w_apply_tok.valid = 1'b1;
        w_apply_tok.apply = 1'b1;
        w_apply_tok.unmap = 1'b0;
        w_apply_tok.wr_en = 1'b0;
        w_apply_tok.wr_mapped = 1'b0;
        w_res_index  = '0;
        w_res_key    = '0;
        w_res_added  = 1'b0;
        w_res_status = STAT_OK;
        n_count      = r_count;
        unique case (w_tail.cmd)
            CMD_PUT: begin
                if (w_tail.hit && !w_tail.force_app) begin
                    w_res_index = w_hit_index;
                end else if (w_full) begin
                    w_res_status = STAT_FULL;
                end else begin
                    w_apply_tok.wr_en     = 1'b1;
                    w_apply_tok.slot      = w_tail.count[SLOT_W-1:0];
                    w_apply_tok.wr_mapped = !w_tail.hit;
                    w_res_index = w_app_index;
                    w_res_added = 1'b1;
                    n_count     = w_tail.count + 1'b1;
                end
            end
            CMD_REPLACE: begin
                if (w_tail.slot_ok) begin
                    w_apply_tok.unmap     = 1'b1;
                    w_apply_tok.wr_en     = 1'b1;
                    w_apply_tok.wr_mapped = 1'b1;
                    w_res_key = w_tail.old_key;
                end else begin
                    w_res_status = STAT_MISS;
                end
            end
            CMD_KEY2IDX: begin
                if (w_tail.hit) begin
                    w_res_index = w_hit_index;
                end else begin
                    w_res_status = STAT_MISS;
                end
            end
            CMD_IDX2KEY: begin
                if (w_tail.slot_ok) begin
                    w_res_key = w_tail.old_key;
                end else begin
                    w_res_status = STAT_MISS;
                end
            end
            default: begin
                w_res_status = STAT_MISS;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_inj         = r_inj;
        n_inj.valid   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_inj   = w_gather_tok;
                    n_state = S_GATHER;
                end
            end
            S_GATHER: begin
                if (w_gather_end) begin
                    n_inj   = w_apply_tok;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_apply_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inj.valid <= 1'b0;
            r_count     <= '0;
            r_base      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj   <= n_inj;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (w_gather_end) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
            end else if (w_load_out) begin
                r_pend  <= 1'b0;
            end
            // hold the response while the receiver stalls
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_gather_end) begin
            r_res_index  <= w_res_index;
            r_res_key    <= w_res_key;
            r_res_added  <= w_res_added;
            r_res_status <= w_res_status;
        end
        if (w_load_out) begin
            r_out_index  <= r_res_index;
            r_out_key    <= r_res_key;
            r_out_added  <= r_res_added;
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.index_out = r_out_index;
    assign o_rsp.key_out   = r_out_key;
    assign o_rsp.was_added = r_out_added;
    assign o_rsp.status    = r_out_status;

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state != S_IDLE))
        else $error("token left the cell row while idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(DEPTH))
        else $error("entry count above depth");

    a_accept_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_state == S_GATHER) && r_inj.valid && !r_inj.apply))
        else $error("request not injected into the cell row");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_gather_end && w_res_added) |=> (r_count == COUNT_W'($past(r_count) + 1'b1)))
        else $error("append did not advance the entry count");

    a_pend_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !r_out_valid) |=> (r_out_valid && !r_pend))
        else $error("pending response not moved to the output");

endmodule

@@ test/kid_checker.sv @@
`timescale 1ns / 1ps

module kid_checker import kid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BASE_W-1:0] i_cfg_wr_data,
    kid_req_if                i_req,
    kid_rsp_if                i_rsp,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_entry_count,
    output int                o_checked
);

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [KEY_W-1:0]  key;
        logic              added;
        logic [STAT_W-1:0] status;
    } t_dict_answer;

    logic [KEY_W-1:0]  slot_key [DEPTH];
    logic              slot_live [DEPTH];
    int                stored;
    logic [BASE_W-1:0] base;
    t_dict_answer      awaited_answers [$];

    function automatic int mapped_slot(input logic [KEY_W-1:0] key);
        for (int s = 0; s < stored; s++) begin
            if (slot_live[s] && slot_key[s] == key) begin
                return s;
            end
        end
        return -1;
    endfunction

    function automatic void drop_mappings(input logic [KEY_W-1:0] key);
        for (int s = 0; s < stored; s++) begin
            if (slot_key[s] == key) begin
                slot_live[s] = 1'b0;
            end
        end
    endfunction

    function automatic t_dict_answer apply_request(input logic [CMD_W-1:0] cmd,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic             frc,
                                                   input logic [IDX_W-1:0] idx);
        t_dict_answer ans;
        int           hit;
        int           rel;
        ans = '0;
        hit = mapped_slot(key);
        rel = int'(idx) - int'(base);
        case (cmd)
            CMD_PUT: begin
                if (hit >= 0 && !frc) begin
                    ans.index = IDX_W'(hit + int'(base));
                end else if (stored >= DEPTH) begin
                    ans.status = STAT_FULL;
                end else begin
                    // an appended entry gets the mapping only if its key has no live mapping yet
                    slot_key[stored]  = key;
                    slot_live[stored] = (hit < 0);
                    ans.index         = IDX_W'(stored + int'(base));
                    ans.added         = 1'b1;
                    stored++;
                end
            end
            CMD_REPLACE, CMD_IDX2KEY: begin
                if (rel < 0 || rel >= stored) begin
                    ans.status = STAT_MISS;
                end else begin
                    ans.key = slot_key[rel];
                    if (cmd == CMD_REPLACE) begin
                        drop_mappings(ans.key);
                        drop_mappings(key);
                        slot_key[rel]  = key;
                        slot_live[rel] = 1'b1;
                    end
                end
            end
            default: begin
                if (hit >= 0) begin
                    ans.index = IDX_W'(hit + int'(base));
                end else begin
                    ans.status = STAT_MISS;
                end
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_dict_answer got;
        t_dict_answer want;
        if (!i_rst_n) begin
            stored = 0;
            base   = '0;
            for (int s = 0; s < DEPTH; s++) begin
                slot_live[s] = 1'b0;
            end
            awaited_answers.delete();
        end else begin
            if (i_cfg_wr_en) begin
                base = i_cfg_wr_data;
            end
            // check the response before queuing a request taken at the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                got.index  = i_rsp.index_out;
                got.key    = i_rsp.key_out;
                got.added  = i_rsp.was_added;
                got.status = i_rsp.status;
                if (awaited_answers.size() == 0) begin
                    $error("response with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = awaited_answers.pop_front();
                    o_checked++;
                    if (got.index !== want.index) begin
                        $error("index_out: expected %0d, got %0d", want.index, got.index);
                        o_fail_count++;
                    end
                    if (got.key !== want.key) begin
                        $error("key_out: expected %08h, got %08h", want.key, got.key);
                        o_fail_count++;
                    end
                    if (got.added !== want.added) begin
                        $error("was_added: expected %0b, got %0b", want.added, got.added);
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_answers.push_back(apply_request(i_req.command, i_req.key_value,
                                                        i_req.force_append, i_req.index_in));
            end
        end
        o_pending     = awaited_answers.size();
        o_entry_count = stored;
    end

endmodule

@@ test/key_index_dictionary_tb.sv @@
`timescale 1ns / 1ps

module key_index_dictionary_tb;
    import kid_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int HOLD_CYCLES = 3000;
    localparam int NUM_PHASES = 5;
    localparam int PHASE_ITEMS = 285;
    localparam int POOL_SIZE = 24;
    localparam int DIR_BASE = 100;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [BASE_W-1:0] cfg_wr_data = '0;

    int fail_count;
    int pending;
    int entries;
    int checked;
    int cycle_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int base_writes = 0;
    int cur_base = 0;
    int hold_off_asked = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               phase_bases [NUM_PHASES];

    kid_req_if req ();
    kid_rsp_if rsp ();

    key_index_dictionary i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req),
        .o_rsp         (rsp)
    );

    kid_checker dict_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req),
        .i_rsp         (rsp),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_entry_count (entries),
        .o_checked     (checked)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("key_index_dictionary test failed");
            $finish;
        end
    end

    // Receiver: stretches of varying readiness, plus one long hold-off on request.
    initial begin
        int pct;
        int len;
        int hold_off_done;
        hold_off_done = 0;
        rsp.ready = 1'b1;
        forever begin
            case ($urandom_range(0, 3))
                0: pct = 100;
                1: pct = 70;
                2: pct = 30;
                default: pct = 5;
            endcase
            len = $urandom_range(20, 1500);
            repeat (len) begin
                @(negedge i_clk);
                if (hold_off_asked != hold_off_done) begin
                    hold_off_done = hold_off_asked;
                    rsp.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                rsp.ready <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic frc, input logic [IDX_W-1:0] idx);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * DEPTH + 8)
                                              : $urandom_range(1, 6);
            req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.key_value    <= key;
        req.force_append <= frc;
        req.index_in     <= idx;
        do @(posedge i_clk); while (!req.ready);
        burst_left--;
        items_sent++;
    endtask

    // Drop valid, wait for every response, then wait settle_cycles so the update pass can finish.
    task automatic drain(input int settle_cycles);
        @(negedge i_clk);
        req.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (settle_cycles) @(negedge i_clk);
    endtask

    task automatic set_index_base(input int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= BASE_W'(value);
        cur_base = value;
        base_writes++;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] choose_key();
        if ($urandom_range(0, 99) < 3) begin
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        end
        if ($urandom_range(0, 99) < 65) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    function automatic logic [IDX_W-1:0] choose_index(input logic [CMD_W-1:0] cmd);
        int pick;
        pick = $urandom_range(0, 99);
        if (cmd == CMD_PUT || cmd == CMD_KEY2IDX) begin
            return IDX_W'($urandom_range(0, 2047));
        end
        if (pick < 75 && entries > 0) begin
            return IDX_W'(cur_base + $urandom_range(0, entries - 1));
        end else if (pick < 85) begin
            return IDX_W'(cur_base + entries + $urandom_range(0, 3));
        end else if (pick < 92 && cur_base > 0) begin
            return IDX_W'($urandom_range(0, cur_base - 1));
        end
        return IDX_W'($urandom_range(0, 2047));
    endfunction

    task automatic random_request();
        logic [CMD_W-1:0] cmd;
        logic             frc;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 33) begin
            cmd = CMD_PUT;
        end else if (pick < 53) begin
            cmd = CMD_REPLACE;
        end else if (pick < 78) begin
            cmd = CMD_KEY2IDX;
        end else begin
            cmd = CMD_IDX2KEY;
        end
        // keep forced appends rare so the table fills late in the run
        frc = (cmd == CMD_PUT) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
        offer_request(cmd, choose_key(), frc, choose_index(cmd));
    endtask

    initial begin
        req.valid        = 1'b0;
        req.command      = CMD_PUT;
        req.key_value    = '0;
        req.force_append = 1'b0;
        req.index_in     = '0;
        for (int p = 0; p < POOL_SIZE; p++) begin
            key_pool[p] = $urandom;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        phase_bases[0] = 1023;
        phase_bases[1] = $urandom_range(1, 1022);
        phase_bases[2] = 0;
        phase_bases[3] = $urandom_range(1, 1022);
        phase_bases[4] = 1023;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_index_base(DIR_BASE);

        // empty table: every lookup misses
        offer_request(CMD_KEY2IDX, '0, 1'b0, '0);
        offer_request(CMD_IDX2KEY, '1, 1'b1, IDX_W'(DIR_BASE));
        offer_request(CMD_REPLACE, 32'hA5A5_5A5A, 1'b0, IDX_W'(DIR_BASE));
        // appends, a hit, a forced duplicate
        offer_request(CMD_PUT, '0, 1'b0, '0);
        offer_request(CMD_PUT, '1, 1'b0, '1);
        offer_request(CMD_PUT, '0, 1'b0, '0);
        offer_request(CMD_PUT, '0, 1'b1, '0);
        offer_request(CMD_KEY2IDX, '0, 1'b1, '1);
        offer_request(CMD_IDX2KEY, '1, 1'b0, IDX_W'(DIR_BASE + 2));
        // rebind drops every mapping of the old key and of the new key
        offer_request(CMD_REPLACE, 32'h1234_5678, 1'b0, IDX_W'(DIR_BASE));
        offer_request(CMD_KEY2IDX, '0, 1'b0, '0);
        offer_request(CMD_KEY2IDX, 32'h1234_5678, 1'b0, '0);
        offer_request(CMD_REPLACE, 32'h1234_5678, 1'b1, IDX_W'(DIR_BASE + 1));
        offer_request(CMD_KEY2IDX, 32'h1234_5678, 1'b0, '0);
        offer_request(CMD_KEY2IDX, '1, 1'b0, '0);
        offer_request(CMD_PUT, '0, 1'b0, '0);
        offer_request(CMD_PUT, 32'h0000_0005, 1'b1, '0);
        offer_request(CMD_REPLACE, 32'h0000_0005, 1'b0, IDX_W'(DIR_BASE + 2));
        // out-of-range indexes: below the base, one past the end, top of range
        offer_request(CMD_IDX2KEY, '0, 1'b0, IDX_W'(DIR_BASE - 1));
        offer_request(CMD_REPLACE, '0, 1'b0, '0);
        offer_request(CMD_IDX2KEY, '0, 1'b0, IDX_W'(DIR_BASE + 5));
        offer_request(CMD_IDX2KEY, '0, 1'b0, '1);
        offer_request(CMD_IDX2KEY, '0, 1'b0, IDX_W'(DIR_BASE + 4));
        offer_request(CMD_KEY2IDX, 32'h0000_0005, 1'b0, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain(SETTLE_CYCLES);
            set_index_base(phase_bases[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 40) begin
                    hold_off_asked = hold_off_asked + 1;
                end
                if (ph == 2 && n == 100) begin
                    drain(0);
                end
                random_request();
            end
        end
        drain(SETTLE_CYCLES);

        $display("Covered %0d requests under %0d index base settings, %0d responses checked",
                 items_sent, base_writes, checked);
        $display("Table ended with %0d of %0d entries, after one long receiver hold-off",
                 entries, DEPTH);
        if (fail_count == 0 && pending == 0) begin
            $display("key_index_dictionary test passed");
        end else begin
            $display("key_index_dictionary test failed");
        end
        $finish;
    end

endmodule
